/* design/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned PrgMaxBanksDef = 256;
  localparam int unsigned ChrMaxBanksDef = 32;

  localparam logic [8:0] PrgCountReset = 9'd16;
  localparam logic [5:0] ChrCountReset = 6'd32;

  typedef enum logic [1:0] {
    CMD_CPU_WRITE = 2'd0,
    CMD_CPU_READ  = 2'd1,
    CMD_PPU_READ  = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PRG  = 2'd1,
    TGT_CHR  = 2'd2,
    TGT_NT   = 2'd3
  } target_e;

  typedef enum logic {
    CFG_PRG_COUNT = 1'b0,
    CFG_CHR_COUNT = 1'b1
  } cfg_reg_e;

  // classified operation handed from the front to the back
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WR_PRG_LOW,
    OP_WR_PRG_MID,
    OP_WR_PRG_HIGH,
    OP_WR_MIRROR,
    OP_WR_CHR_LOWER,
    OP_WR_CHR_UPPER,
    OP_RD_PRG,
    OP_RD_PRG_LAST,
    OP_RD_CHR,
    OP_RD_NT
  } op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] mapped_address;
    logic        mirror_horizontal;
  } out_word_t;

  typedef struct packed {
    op_e         kind;
    logic [1:0]  window;
    logic [12:0] offset;
    logic [7:0]  data;
  } op_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [8:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] remainder;
  } rem_rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV_A,
    BK_DIV_B
  } bk_state_e;

endpackage

/* design/cbm_front.sv */
// ----------------------------------------------------------------------------
// cbm_front
// Accepts bus accesses, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
module cbm_front import cbm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word_i,
  output logic     q_valid_o,
  output op_t      q_head_o,
  input  logic     q_pop_i
);

  op_t        cls;
  op_t        entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push_fire, pop_fire;

  always_comb begin
    cls.kind   = OP_NONE;
    cls.window = in_word_i.address[14:13];
    cls.offset = in_word_i.address[12:0];
    cls.data   = in_word_i.write_data;
    case (cmd_e'(in_word_i.command))
      CMD_CPU_WRITE: begin
        case (in_word_i.address[15:12])
          4'h8:    cls.kind = OP_WR_PRG_LOW;
          4'h9:    cls.kind = OP_WR_MIRROR;
          4'hA:    cls.kind = OP_WR_PRG_MID;
          4'hC:    cls.kind = OP_WR_PRG_HIGH;
          4'hE:    cls.kind = OP_WR_CHR_LOWER;
          4'hF:    cls.kind = OP_WR_CHR_UPPER;
          default: cls.kind = OP_NONE;
        endcase
      end
      CMD_CPU_READ: begin
        if (in_word_i.address[15]) begin
          cls.kind = (in_word_i.address[14:13] == 2'b11) ? OP_RD_PRG_LAST : OP_RD_PRG;
        end
      end
      CMD_PPU_READ: begin
        // only a13..a0 of the ppu bus matter, a13 splits pattern and nametable
        cls.window = {1'b0, in_word_i.address[12]};
        cls.offset = {1'b0, in_word_i.address[11:0]};
        if (!in_word_i.address[13]) begin
          cls.kind = OP_RD_CHR;
        end else if (in_word_i.address[13:8] != 6'h3F) begin
          cls.kind = OP_RD_NT;
        end
      end
      default: cls.kind = OP_NONE;
    endcase
  end

  assign full      = (count_q == 2'd2);
  assign push_fire = push && !full;
  assign pop_fire  = q_pop_i && (count_q != 2'd0);
  assign q_valid_o = (count_q != 2'd0);
  assign q_head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_fire ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_fire ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_fire && !pop_fire) begin
      count_d = count_q + 2'd1;
    end else if (!push_fire && pop_fire) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entries_q[wr_ptr_q] <= cls;
    end
  end

endmodule

/* design/cbm_rem.sv */
// ----------------------------------------------------------------------------
// cbm_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cbm_rem import cbm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] dvd_q, dvd_d;
  logic [8:0] dvs_q, dvs_d;
  logic [8:0] trial;

  // partial remainder stays below the divisor, so it fits in eight bits
  assign trial = {rem_q, dvd_q[7]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      rem_d  = 8'd0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = (trial >= dvs_q) ? 8'(trial - dvs_q) : trial[7:0];
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* design/cbm_back.sv */
// ----------------------------------------------------------------------------
// cbm_back
// Holds bank state and counts, runs queued operations, keeps the result word.
// ----------------------------------------------------------------------------
module cbm_back import cbm_pkg::*; #(
  parameter int unsigned MAX_PRG_BANKS = PrgMaxBanksDef,
  parameter int unsigned MAX_CHR_BANKS = ChrMaxBanksDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  cfg_reg_e  cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  logic      q_valid_i,
  input  op_t       q_head_i,
  output logic      q_pop_o,
  output rem_req_t  rem_req_o,
  input  rem_rsp_t  rem_rsp_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  localparam logic [8:0] PrgMax = 9'(MAX_PRG_BANKS);
  localparam logic [5:0] ChrMax = 6'(MAX_CHR_BANKS);

  logic [8:0] prg_cnt_q;
  logic [5:0] chr_cnt_q;
  logic [7:0] prg_low_q, prg_mid_q, prg_high_q;
  logic [4:0] chr_lower_q, chr_upper_q;
  logic       mirror_q;

  bk_state_e  state_q, state_d;
  op_t        op_q;
  out_word_t  out_q;
  logic       out_valid_q;

  logic [8:0] pc, pc_m1;
  logic [5:0] cc;
  op_t        cur;
  logic       cur_div;
  logic       out_free;
  logic       deq, latch_op, load_out, start_a, start_b;
  out_word_t  res;
  logic [7:0] dvd_a;

  function automatic logic needs_div(input op_e k);
    case (k)
      OP_WR_PRG_LOW, OP_WR_PRG_MID, OP_WR_PRG_HIGH, OP_WR_MIRROR,
      OP_WR_CHR_LOWER, OP_WR_CHR_UPPER, OP_RD_PRG, OP_RD_CHR: needs_div = 1'b1;
      default: needs_div = 1'b0;
    endcase
  endfunction

  function automatic logic is_chr(input op_e k);
    case (k)
      OP_WR_MIRROR, OP_WR_CHR_LOWER, OP_WR_CHR_UPPER, OP_RD_CHR: is_chr = 1'b1;
      default: is_chr = 1'b0;
    endcase
  endfunction

  // zero counts act as one, counts above the limit act as the limit
  always_comb begin
    pc = prg_cnt_q;
    if (prg_cnt_q == 9'd0) begin
      pc = 9'd1;
    end else if (prg_cnt_q > PrgMax) begin
      pc = PrgMax;
    end
    cc = chr_cnt_q;
    if (chr_cnt_q == 6'd0) begin
      cc = 6'd1;
    end else if (chr_cnt_q > ChrMax) begin
      cc = ChrMax;
    end
  end
  assign pc_m1 = pc - 9'd1;

  assign cur      = (state_q == BK_IDLE) ? q_head_i : op_q;
  assign cur_div  = needs_div(q_head_i.kind);
  assign out_free = !out_valid_q || pop;

  always_comb begin
    case (cur.kind)
      OP_WR_PRG_LOW, OP_WR_PRG_MID, OP_WR_PRG_HIGH: dvd_a = cur.data;
      OP_WR_CHR_LOWER: dvd_a = {3'd0, chr_lower_q[4], cur.data[3:0]};
      OP_WR_CHR_UPPER: dvd_a = {3'd0, chr_upper_q[4], cur.data[3:0]};
      OP_WR_MIRROR:    dvd_a = {3'd0, cur.data[1], chr_lower_q[3:0]};
      OP_RD_PRG: begin
        case (cur.window)
          2'd0:    dvd_a = prg_low_q;
          2'd1:    dvd_a = prg_mid_q;
          default: dvd_a = prg_high_q;
        endcase
      end
      OP_RD_CHR: dvd_a = {3'd0, cur.window[0] ? chr_upper_q : chr_lower_q};
      default:   dvd_a = 8'd0;
    endcase
  end

  always_comb begin
    rem_req_o.start    = start_a || start_b;
    rem_req_o.dividend = start_b ? {3'd0, op_q.data[2], chr_upper_q[3:0]} : dvd_a;
    rem_req_o.divisor  = is_chr(cur.kind) ? {3'd0, cc} : pc;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && cur_div && !out_valid_q) begin
          state_d = BK_DIV_A;
        end
      end
      BK_DIV_A: begin
        if (rem_rsp_i.done) begin
          state_d = (op_q.kind == OP_WR_MIRROR) ? BK_DIV_B : BK_IDLE;
        end
      end
      BK_DIV_B: begin
        if (rem_rsp_i.done) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    deq      = 1'b0;
    latch_op = 1'b0;
    load_out = 1'b0;
    start_a  = 1'b0;
    start_b  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (cur_div) begin
            if (!out_valid_q) begin
              deq      = 1'b1;
              latch_op = 1'b1;
              start_a  = 1'b1;
            end
          end else if (out_free) begin
            deq      = 1'b1;
            load_out = 1'b1;
          end
        end
      end
      BK_DIV_A: begin
        if (rem_rsp_i.done) begin
          if (op_q.kind == OP_WR_MIRROR) begin
            start_b = 1'b1;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      BK_DIV_B: begin
        load_out = rem_rsp_i.done;
      end
      default: ;
    endcase
  end
  assign q_pop_o = deq;

  always_comb begin
    res.target            = TGT_NONE;
    res.mapped_address    = 21'd0;
    res.mirror_horizontal = mirror_q;
    case (cur.kind)
      OP_RD_PRG: begin
        res.target         = TGT_PRG;
        res.mapped_address = {rem_rsp_i.remainder, cur.offset};
      end
      OP_RD_PRG_LAST: begin
        res.target         = TGT_PRG;
        res.mapped_address = {pc_m1[7:0], cur.offset};
      end
      OP_RD_CHR: begin
        res.target         = TGT_CHR;
        res.mapped_address = {4'd0, rem_rsp_i.remainder[4:0], cur.offset[11:0]};
      end
      OP_RD_NT: begin
        res.target = TGT_NT;
        // horizontal mirroring takes a11 as the page bit
        res.mapped_address = mirror_q ? {10'd0, cur.offset[11], cur.offset[9:0]}
                                      : {10'd0, cur.offset[10:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      prg_cnt_q   <= PrgCountReset;
      chr_cnt_q   <= ChrCountReset;
      prg_low_q   <= 8'd0;
      prg_mid_q   <= 8'd1;
      prg_high_q  <= 8'd2;
      chr_lower_q <= 5'd0;
      chr_upper_q <= 5'd1;
      mirror_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PRG_COUNT: prg_cnt_q <= cfg_data_i;
          CFG_CHR_COUNT: chr_cnt_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (latch_op && q_head_i.kind == OP_WR_MIRROR) begin
        mirror_q <= q_head_i.data[0];
      end
      if (state_q == BK_DIV_A && rem_rsp_i.done) begin
        case (op_q.kind)
          OP_WR_PRG_LOW:   prg_low_q   <= rem_rsp_i.remainder;
          OP_WR_PRG_MID:   prg_mid_q   <= rem_rsp_i.remainder;
          OP_WR_PRG_HIGH:  prg_high_q  <= rem_rsp_i.remainder;
          OP_WR_CHR_LOWER: chr_lower_q <= rem_rsp_i.remainder[4:0];
          OP_WR_MIRROR:    chr_lower_q <= rem_rsp_i.remainder[4:0];
          OP_WR_CHR_UPPER: chr_upper_q <= rem_rsp_i.remainder[4:0];
          default: ;
        endcase
      end
      if (state_q == BK_DIV_B && rem_rsp_i.done) begin
        chr_upper_q <= rem_rsp_i.remainder[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch_op) begin
      op_q <= q_head_i;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

endmodule

/* design/cartridge_bank_mapper.sv */
// Path: nametable, fixed-bank and unmapped accesses go from the queue entry to the result register;
// switchable bank reads and bank writes run a bank reduction in between, a 9000 write two of them.
// Throughput: one word per cycle for accesses without a bank reduction while the output is popped; a
// reduction holds the one-bit-per-cycle remainder unit and waits for the output to drain, and no
// further access is taken until its result word is loaded; a 9000 write runs two reductions.
// Reset: queues empty, banks 0/1/2 and 0/1, vertical mirroring, counts 16 and 32.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Bank switching mapper: decode front, operation queue, sequenced back end.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper import cbm_pkg::*; #(
  parameter int unsigned MAX_PRG_BANKS = PrgMaxBanksDef,
  parameter int unsigned MAX_CHR_BANKS = ChrMaxBanksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_word_t   in_word_i,
  output logic       empty,
  input  logic       pop,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  cfg_reg_e   cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  logic     q_valid;
  op_t      q_head;
  logic     q_pop;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  assign cfg_ready_o = 1'b1;

  cbm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .q_valid_o (q_valid),
    .q_head_o  (q_head),
    .q_pop_i   (q_pop)
  );

  cbm_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  cbm_back #(
    .MAX_PRG_BANKS (MAX_PRG_BANKS),
    .MAX_CHR_BANKS (MAX_CHR_BANKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .rem_req_o   (rem_req),
    .rem_rsp_i   (rem_rsp),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cartridge bank mapper. A driver and a monitor
// run as clocked blocks around the queue-style ports. The monitor predicts
// the result of each accepted access from its own copy of the bank
// registers and counts, and checks the results in order. Count registers are
// reprogrammed between phases, and the sender and receiver idle at random.
// ----------------------------------------------------------------------------
module testbench import cbm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles  = 25;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned WordsPerPhase = 100;
  localparam int unsigned MaxReports    = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_word_t   in_word_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_word_t  out_word_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  cfg_reg_e   cfg_index_i = CFG_PRG_COUNT;
  logic [8:0] cfg_data_i = '0;

  cartridge_bank_mapper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // pending accesses and expected result words
  in_word_t    access_queue[$];
  out_word_t   expected_words[$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  logic        push_taken = 1'b0;

  // shadow of the mapper state
  logic [8:0] prg_count_q = PrgCountReset;
  logic [5:0] chr_count_q = ChrCountReset;
  logic [7:0] prg_low_q = 8'd0;
  logic [7:0] prg_mid_q = 8'd1;
  logic [7:0] prg_high_q = 8'd2;
  logic [4:0] chr_lower_q = 5'd0;
  logic [4:0] chr_upper_q = 5'd1;
  logic       mirror_q = 1'b0;

  function automatic out_word_t map_access(in_word_t w);
    out_word_t   res;
    int unsigned pc;
    int unsigned cc;
    int unsigned bank;
    int unsigned v;
    logic [13:0] pa;
    logic [11:0] na;
    pc = (prg_count_q == 0) ? 1 : (prg_count_q > PrgMaxBanksDef) ? PrgMaxBanksDef
                                                                  : prg_count_q;
    cc = (chr_count_q == 0) ? 1 : (chr_count_q > ChrMaxBanksDef) ? ChrMaxBanksDef
                                                                  : chr_count_q;
    v = w.write_data;
    res = '0;
    case (cmd_e'(w.command))
      CMD_CPU_WRITE: begin
        case (w.address[15:12])
          4'h8: prg_low_q = 8'(v % pc);
          4'h9: begin
            mirror_q = w.write_data[0];
            chr_lower_q = 5'({w.write_data[1], chr_lower_q[3:0]} % cc);
            chr_upper_q = 5'({w.write_data[2], chr_upper_q[3:0]} % cc);
          end
          4'hA: prg_mid_q = 8'(v % pc);
          4'hC: prg_high_q = 8'(v % pc);
          4'hE: chr_lower_q = 5'({chr_lower_q[4], w.write_data[3:0]} % cc);
          4'hF: chr_upper_q = 5'({chr_upper_q[4], w.write_data[3:0]} % cc);
          default: ;
        endcase
      end
      CMD_CPU_READ: begin
        if (w.address[15]) begin
          if (w.address < 16'hA000) bank = prg_low_q;
          else if (w.address < 16'hC000) bank = prg_mid_q;
          else if (w.address < 16'hE000) bank = prg_high_q;
          else bank = pc - 1;
          // stale bank numbers are reduced against the current count
          bank = bank % pc;
          res.target = TGT_PRG;
          res.mapped_address = 21'(bank * 32'h2000 + w.address[12:0]);
        end
      end
      CMD_PPU_READ: begin
        pa = w.address[13:0];
        if (pa < 14'h2000) begin
          bank = pa[12] ? chr_upper_q : chr_lower_q;
          bank = bank % cc;
          res.target = TGT_CHR;
          res.mapped_address = 21'(bank * 32'h1000 + pa[11:0]);
        end else if (pa < 14'h3F00) begin
          na = pa[11:0];
          res.target = TGT_NT;
          res.mapped_address = mirror_q ? 21'({na[11], na[9:0]}) : 21'(na[10:0]);
        end
      end
      default: ;
    endcase
    res.mirror_horizontal = mirror_q;
    return res;
  endfunction

  function automatic in_word_t random_access();
    in_word_t    w;
    int unsigned pick;
    w.write_data = 8'($urandom_range(255, 0));
    w.address = 16'($urandom_range(65535, 0));
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      w.command = CMD_CPU_WRITE;
      // mostly bank register writes, the rest go to random addresses
      if ($urandom_range(9, 0) != 0) begin
        case ($urandom_range(5, 0))
          0: w.address[15:12] = 4'h8;
          1: w.address[15:12] = 4'h9;
          2: w.address[15:12] = 4'hA;
          3: w.address[15:12] = 4'hC;
          4: w.address[15:12] = 4'hE;
          default: w.address[15:12] = 4'hF;
        endcase
      end
    end else if (pick < 70) begin
      w.command = CMD_CPU_READ;
      if ($urandom_range(9, 0) != 0) w.address[15] = 1'b1;
    end else if (pick < 96) begin
      w.command = CMD_PPU_READ;
      if ($urandom_range(9, 0) == 0) w.address[13:8] = 6'h3F;
    end else begin
      w.command = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic queue_access(cmd_e cmd, logic [15:0] addr, logic [7:0] data);
    in_word_t w;
    w.command = cmd;
    w.address = addr;
    w.write_data = data;
    access_queue.push_back(w);
    queued_count++;
  endtask

  task automatic write_count(cfg_reg_e idx, logic [8:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || expected_words.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic note_error();
    error_count++;
    if (error_count == MaxReports) $display("further mismatches are only counted");
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push || push_taken) begin
        if (access_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_word_i <= access_queue.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99, 0) >= pop_stall_pct);
    end
  end

  // monitor: predicts on acceptance, checks on pop
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      push_taken <= push && !full;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_PRG_COUNT) prg_count_q = cfg_data_i;
        else chr_count_q = cfg_data_i[5:0];
      end
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          if (error_count < MaxReports) begin
            $display("%0t: unexpected word target %0d addr 'h%06h mirror %0b", $realtime,
                     out_word_o.target, out_word_o.mapped_address,
                     out_word_o.mirror_horizontal);
          end
          note_error();
        end else begin
          want = expected_words.pop_front();
          checked_count++;
          if (out_word_o !== want) begin
            if (error_count < MaxReports) begin
              $display("%0t: mismatch expected target %0d addr 'h%06h mirror %0b", $realtime,
                       want.target, want.mapped_address, want.mirror_horizontal);
              $display("%0t:          actual   target %0d addr 'h%06h mirror %0b", $realtime,
                       out_word_o.target, out_word_o.mapped_address,
                       out_word_o.mirror_horizontal);
            end
            note_error();
          end
        end
      end
      if (push && !full) begin
        expected_words.push_back(map_access(in_word_i));
        accepted_count++;
      end
    end
  end

  initial begin
    logic [8:0]  prg_setting;
    logic [8:0]  chr_setting;
    int unsigned mode;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed accesses at the reset counts, first reads with the reset banks in place, then bank writes
    queue_access(CMD_CPU_READ, 16'h8000, 8'h00);
    queue_access(CMD_CPU_READ, 16'hBFFF, 8'hFF);
    queue_access(CMD_CPU_READ, 16'hC000, 8'h00);
    queue_access(CMD_CPU_READ, 16'hFFFF, 8'h00);
    queue_access(CMD_CPU_READ, 16'h0000, 8'h00);
    queue_access(CMD_PPU_READ, 16'h0000, 8'h00);
    queue_access(CMD_PPU_READ, 16'h1FFF, 8'h00);
    queue_access(CMD_PPU_READ, 16'h2000, 8'h00);
    queue_access(CMD_PPU_READ, 16'h3EFF, 8'h00);
    queue_access(CMD_PPU_READ, 16'h3F00, 8'h00);
    queue_access(CMD_PPU_READ, 16'hFFFF, 8'h00);
    queue_access(CMD_CPU_WRITE, 16'h9000, 8'hFF);
    queue_access(CMD_PPU_READ, 16'h2C00, 8'h00);
    queue_access(CMD_PPU_READ, 16'h3ABC, 8'h00);
    queue_access(CMD_CPU_WRITE, 16'hEFFF, 8'hFF);
    queue_access(CMD_CPU_WRITE, 16'hF000, 8'h0F);
    queue_access(CMD_PPU_READ, 16'h0FFF, 8'h00);
    queue_access(CMD_PPU_READ, 16'h7000, 8'h00);
    queue_access(CMD_CPU_WRITE, 16'h8000, 8'hFF);
    queue_access(CMD_CPU_WRITE, 16'hA123, 8'h00);
    queue_access(CMD_CPU_WRITE, 16'hCFFF, 8'hAA);
    queue_access(CMD_CPU_WRITE, 16'hB000, 8'h55);
    queue_access(CMD_CPU_WRITE, 16'hD000, 8'h55);
    queue_access(CMD_CPU_WRITE, 16'h7FFF, 8'hFF);
    queue_access(CMD_UNUSED, 16'hFFFF, 8'hFF);
    queue_access(CMD_CPU_READ, 16'h9FFF, 8'h00);
    queue_access(CMD_CPU_READ, 16'hA000, 8'h00);
    queue_access(CMD_CPU_READ, 16'hDFFF, 8'h00);
    queue_access(CMD_CPU_WRITE, 16'h9000, 8'h00);
    queue_access(CMD_PPU_READ, 16'h2C00, 8'h00);
    wait_drained();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin prg_setting = 9'd256; chr_setting = 9'd32; end
        1: begin prg_setting = 9'd1;   chr_setting = 9'd1;  end
        2: begin prg_setting = 9'd0;   chr_setting = 9'd0;  end
        3: begin prg_setting = 9'd511; chr_setting = 9'd63; end
        4: begin prg_setting = 9'd7;   chr_setting = 9'd20; end
        default: begin
          prg_setting = 9'($urandom_range(511, 0));
          chr_setting = 9'($urandom_range(511, 0));
        end
      endcase
      write_count(CFG_PRG_COUNT, prg_setting);
      write_count(CFG_CHR_COUNT, chr_setting);
      mode = phase % 4;
      send_idle_pct = (mode == 1) ? 49 : (mode == 3) ? 20 : 0;
      pop_stall_pct = (mode == 2) ? 49 : (mode == 3) ? 20 : 0;
      for (int n = 0; n < WordsPerPhase; n++) begin
        access_queue.push_back(random_access());
        queued_count++;
      end
      wait_drained();
    end

    $display("%0d accesses sent, %0d result words checked", queued_count, checked_count);
    $display("%0d count settings incl. zero and over-range, four idle modes",
             RandomPhases + 1);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("cartridge_bank_mapper test passed");
    end else begin
      $display("cartridge_bank_mapper test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout after %0t", $realtime);
    $display("cartridge_bank_mapper test failed");
    $finish;
  end

endmodule
